@@ hw/rtl/esht_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esht_pkg: shared types and constants of the endpoint session hash table
// Command and status codes, the queued job record and the state enums.
// ----------------------------------------------------------------------------
package esht_pkg;

    localparam int ENTRIES_DEF  = 1024;
    localparam int SIZE_W       = 11;
    localparam int ADDR_W       = 32;
    localparam int PORT_W       = 16;
    localparam int KEY_W        = ADDR_W + PORT_W;
    localparam int DATA_W       = 32;
    localparam int SUM_W        = 18;
    localparam int OUT_BUCKET_W = 10;
    localparam int CNT_W        = $clog2(SUM_W);

    typedef enum logic [1:0] {
        CMD_ADD = 2'd0,
        CMD_DEL = 2'd1,
        CMD_GET = 2'd2,
        CMD_NOP = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2,
        ST_OFF  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        CLS_OFF,
        CLS_ADD,
        CLS_DEL,
        CLS_GET,
        CLS_NOP
    } t_cls;

    typedef struct packed {
        t_cls               cls;
        logic [KEY_W-1:0]   key;
        logic [DATA_W-1:0]  data;
        logic [SIZE_W-1:0]  bucket;
    } t_job;

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_HASH,
        FR_PUSH
    } t_front_state;

    typedef enum logic [3:0] {
        B_CLEAR,
        B_IDLE,
        B_ADD0,
        B_ADD1,
        B_ADD2,
        B_FIND0,
        B_FIND1,
        B_WALK,
        B_RES
    } t_back_state;

endpackage

@@ hw/rtl/endpoint_session_hash_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// endpoint_session_hash_table: chained session table keyed by address/port
// Front hashes the key, back runs the command against the table memories.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel i_valid/o_stall carries command, address, port, payload;
//   output channel o_valid/i_stall returns status, found_payload, bucket,
//   one result transaction per input transaction, in order.
//   table_size is written with i_cfg_we/i_table_size while idle; a write
//   empties every bucket and refills the free pool.
// Flow: the front runs the bit-serial modulo, then the back steps an add
//   through B_ADD0, B_ADD1 and B_ADD2, and a delete or look up through
//   B_FIND0, B_FIND1 and a B_WALK step per chain node visited, then loads
//   the result register. A disabled table skips the modulo. One transaction
//   is in the front and one in the back at a time; the front takes no new
//   transaction until it has queued the last one, and while the chains are
//   short the back keeps pace; on long chains the walk over the node memories sets the rate.
// Reset, and every size write, start a clearing pass over every bucket
//   head; o_stall is high during it.
// A stalled output holds its result; the back waits, the queue fills and
//   the input stalls in turn.
// ----------------------------------------------------------------------------
module endpoint_session_hash_table #(
    parameter int ENTRIES = esht_pkg::ENTRIES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [esht_pkg::SIZE_W-1:0]         i_table_size,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [1:0]                          i_command,
    input  logic [esht_pkg::ADDR_W-1:0]         i_address,
    input  logic [esht_pkg::PORT_W-1:0]         i_port,
    input  logic [esht_pkg::DATA_W-1:0]         i_payload,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [1:0]                          o_status,
    output logic [esht_pkg::DATA_W-1:0]         o_found_payload,
    output logic [esht_pkg::OUT_BUCKET_W-1:0]   o_bucket
);

    logic [esht_pkg::SIZE_W-1:0] r_size;
    logic [esht_pkg::SIZE_W-1:0] n_in_use;
    logic [esht_pkg::SIZE_W-1:0] cfg_n;
    logic                        q_push;
    logic                        q_pop;
    logic                        q_full;
    logic                        q_empty;
    esht_pkg::t_job              q_in;
    esht_pkg::t_job              q_out;
    logic                        clearing;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= '0;
        end else if (i_cfg_we) begin
            r_size <= i_table_size;
        end
    end

    // clamp to the node store
    assign n_in_use = (32'(r_size) > 32'(ENTRIES)) ? esht_pkg::SIZE_W'(ENTRIES) : r_size;
    assign cfg_n    = (32'(i_table_size) > 32'(ENTRIES)) ? esht_pkg::SIZE_W'(ENTRIES)
                                                         : i_table_size;

    esht_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_command  (i_command),
        .i_address  (i_address),
        .i_port     (i_port),
        .i_payload  (i_payload),
        .i_n        (n_in_use),
        .i_clearing (clearing),
        .i_q_full   (q_full),
        .o_q_push   (q_push),
        .o_q_data   (q_in)
    );

    esht_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_out)
    );

    esht_back #(.ENTRIES(ENTRIES)) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_n             (n_in_use),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_n         (cfg_n),
        .i_q_empty       (q_empty),
        .i_q_data        (q_out),
        .o_q_pop         (q_pop),
        .o_clearing      (clearing),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_status        (o_status),
        .o_found_payload (o_found_payload),
        .o_bucket        (o_bucket)
    );

endmodule

@@ hw/rtl/esht_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esht_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle, no reset on the contents.
// ----------------------------------------------------------------------------
module esht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/esht_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esht_queue: two-entry job queue between front and back
// Decouples hashing from table execution so either side can stall.
// ----------------------------------------------------------------------------
module esht_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  esht_pkg::t_job i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output esht_pkg::t_job o_data
);

    esht_pkg::t_job r_slot [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr] <= i_data;
        end
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_slot[r_rd];

endmodule

@@ hw/rtl/esht_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esht_front: command intake and bucket hash
// Accepts a transaction, folds the key, reduces it modulo the table size
// one bit per cycle unless the table is off, then queues the classified job.
// ----------------------------------------------------------------------------
module esht_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [1:0]                    i_command,
    input  logic [esht_pkg::ADDR_W-1:0]   i_address,
    input  logic [esht_pkg::PORT_W-1:0]   i_port,
    input  logic [esht_pkg::DATA_W-1:0]   i_payload,
    input  logic [esht_pkg::SIZE_W-1:0]   i_n,
    input  logic                          i_clearing,
    input  logic                          i_q_full,
    output logic                          o_q_push,
    output esht_pkg::t_job                o_q_data
);

    esht_pkg::t_front_state r_state, n_state;
    esht_pkg::t_job         r_job, n_job;
    logic [esht_pkg::SUM_W-1:0]  r_sum, n_sum;
    logic [esht_pkg::SIZE_W-1:0] r_rem, n_rem;
    logic [esht_pkg::CNT_W-1:0]  r_cnt, n_cnt;

    logic                        accept;
    logic [esht_pkg::SIZE_W:0]   rem2;
    logic [esht_pkg::SUM_W-1:0]  fold;

    assign o_stall  = (r_state != esht_pkg::FR_IDLE) || i_clearing;
    assign accept   = i_valid && !o_stall;
    assign o_q_data = r_job;
    assign fold     = esht_pkg::SUM_W'(i_address[31:16]) + esht_pkg::SUM_W'(i_address[15:0])
                    + esht_pkg::SUM_W'(i_port);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= esht_pkg::FR_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job <= n_job;
        r_sum <= n_sum;
        r_rem <= n_rem;
        r_cnt <= n_cnt;
    end

    always_comb begin
        n_state  = r_state;
        n_job    = r_job;
        n_sum    = r_sum;
        n_rem    = r_rem;
        n_cnt    = r_cnt;
        o_q_push = 1'b0;
        rem2     = {r_rem, r_sum[esht_pkg::SUM_W-1]};
        case (r_state)
            esht_pkg::FR_IDLE: begin
                if (accept) begin
                    n_job.key  = {i_address, i_port};
                    n_job.data = i_payload;
                    case (esht_pkg::t_cmd'(i_command))
                        esht_pkg::CMD_ADD: n_job.cls = esht_pkg::CLS_ADD;
                        esht_pkg::CMD_DEL: n_job.cls = esht_pkg::CLS_DEL;
                        esht_pkg::CMD_GET: n_job.cls = esht_pkg::CLS_GET;
                        default:           n_job.cls = esht_pkg::CLS_NOP;
                    endcase
                    if (i_n == '0) begin
                        n_job.cls    = esht_pkg::CLS_OFF;
                        n_job.bucket = '0;
                        n_state      = esht_pkg::FR_PUSH;
                    end else begin
                        n_sum   = fold;
                        n_rem   = '0;
                        n_cnt   = esht_pkg::CNT_W'(esht_pkg::SUM_W - 1);
                        n_state = esht_pkg::FR_HASH;
                    end
                end
            end
            esht_pkg::FR_HASH: begin
                // restoring remainder step
                if (rem2 >= {1'b0, i_n}) begin
                    rem2 = rem2 - {1'b0, i_n};
                end
                n_rem = rem2[esht_pkg::SIZE_W-1:0];
                n_sum = {r_sum[esht_pkg::SUM_W-2:0], 1'b0};
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_job.bucket = rem2[esht_pkg::SIZE_W-1:0];
                    n_state      = esht_pkg::FR_PUSH;
                end
            end
            esht_pkg::FR_PUSH: begin
                if (!i_q_full) begin
                    o_q_push = 1'b1;
                    n_state  = esht_pkg::FR_IDLE;
                end
            end
            default: begin
                n_state = esht_pkg::FR_IDLE;
            end
        endcase
    end

endmodule

@@ hw/rtl/esht_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esht_back: table execution unit
// Runs add, delete and look up against the bucket heads, node store and
// free pool, walks chains one node per cycle and holds the result register.
// ----------------------------------------------------------------------------
module esht_back #(
    parameter int ENTRIES = esht_pkg::ENTRIES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [esht_pkg::SIZE_W-1:0]         i_n,
    input  logic                                i_cfg_we,
    input  logic [esht_pkg::SIZE_W-1:0]         i_cfg_n,
    input  logic                                i_q_empty,
    input  esht_pkg::t_job                      i_q_data,
    output logic                                o_q_pop,
    output logic                                o_clearing,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [1:0]                          o_status,
    output logic [esht_pkg::DATA_W-1:0]         o_found_payload,
    output logic [esht_pkg::OUT_BUCKET_W-1:0]   o_bucket
);

    localparam int IW = $clog2(ENTRIES);
    localparam int LW = $clog2(ENTRIES + 1);
    localparam int KW = esht_pkg::KEY_W + esht_pkg::DATA_W;
    localparam int SW = esht_pkg::SIZE_W;

    esht_pkg::t_back_state r_state, n_state;
    esht_pkg::t_job        r_job, n_job;
    logic [SW-1:0]         r_fc, n_fc;
    logic [SW-1:0]         r_virt, n_virt;
    logic [IW-1:0]         r_clr, n_clr;
    logic [LW-1:0]         r_h, n_h;
    logic [IW-1:0]         r_idx, n_idx;
    esht_pkg::t_status     r_rstat, n_rstat;
    logic [esht_pkg::DATA_W-1:0] r_rfound, n_rfound;

    logic                  r_ovalid, n_ovalid;
    esht_pkg::t_status     r_ostatus, n_ostatus;
    logic [esht_pkg::DATA_W-1:0]       r_ofound, n_ofound;
    logic [esht_pkg::OUT_BUCKET_W-1:0] r_obucket, n_obucket;

    // memory ports
    logic          head_we;
    logic [IW-1:0] head_waddr;
    logic [LW-1:0] head_wdata;
    logic [LW-1:0] head_rdata;
    logic          kv_we;
    logic [IW-1:0] kv_waddr;
    logic [KW-1:0] kv_wdata;
    logic [KW-1:0] kv_rdata;
    logic          next_we;
    logic [IW-1:0] next_waddr;
    logic [LW-1:0] next_wdata;
    logic [LW-1:0] next_rdata;
    logic          prev_we;
    logic [IW-1:0] prev_waddr;
    logic [LW-1:0] prev_wdata;
    logic [LW-1:0] prev_rdata;
    logic          free_we;
    logic [IW-1:0] free_waddr;
    logic [IW-1:0] free_wdata;
    logic [IW-1:0] free_rdata;
    logic [IW-1:0] node_raddr;
    logic [IW-1:0] head_raddr;
    logic [IW-1:0] free_raddr;

    logic [SW-1:0] pos;
    logic [IW-1:0] new_idx;

    assign head_raddr = IW'(r_job.bucket);
    assign free_raddr = IW'(r_fc - 1'b1);
    assign pos        = r_fc - 1'b1;
    // slots below the low-water mark were never popped since the last clear
    assign new_idx    = (pos < r_virt) ? IW'(i_n - 1'b1 - pos) : free_rdata;

    assign o_clearing      = (r_state == esht_pkg::B_CLEAR);
    assign o_valid         = r_ovalid;
    assign o_status        = r_ostatus;
    assign o_found_payload = r_ofound;
    assign o_bucket        = r_obucket;

    esht_ram #(.WIDTH(LW), .DEPTH(ENTRIES)) u_head (
        .i_clk(i_clk), .i_we(head_we), .i_waddr(head_waddr), .i_wdata(head_wdata),
        .i_raddr(head_raddr), .o_rdata(head_rdata)
    );
    esht_ram #(.WIDTH(KW), .DEPTH(ENTRIES)) u_kv (
        .i_clk(i_clk), .i_we(kv_we), .i_waddr(kv_waddr), .i_wdata(kv_wdata),
        .i_raddr(node_raddr), .o_rdata(kv_rdata)
    );
    esht_ram #(.WIDTH(LW), .DEPTH(ENTRIES)) u_next (
        .i_clk(i_clk), .i_we(next_we), .i_waddr(next_waddr), .i_wdata(next_wdata),
        .i_raddr(node_raddr), .o_rdata(next_rdata)
    );
    esht_ram #(.WIDTH(LW), .DEPTH(ENTRIES)) u_prev (
        .i_clk(i_clk), .i_we(prev_we), .i_waddr(prev_waddr), .i_wdata(prev_wdata),
        .i_raddr(node_raddr), .o_rdata(prev_rdata)
    );
    esht_ram #(.WIDTH(IW), .DEPTH(ENTRIES)) u_free (
        .i_clk(i_clk), .i_we(free_we), .i_waddr(free_waddr), .i_wdata(free_wdata),
        .i_raddr(free_raddr), .o_rdata(free_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= esht_pkg::B_CLEAR;
            r_fc     <= '0;
            r_virt   <= '0;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_fc     <= n_fc;
            r_virt   <= n_virt;
            r_clr    <= n_clr;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job     <= n_job;
        r_h       <= n_h;
        r_idx     <= n_idx;
        r_rstat   <= n_rstat;
        r_rfound  <= n_rfound;
        r_ostatus <= n_ostatus;
        r_ofound  <= n_ofound;
        r_obucket <= n_obucket;
    end

    always_comb begin
        n_state    = r_state;
        n_job      = r_job;
        n_fc       = r_fc;
        n_virt     = r_virt;
        n_clr      = r_clr;
        n_h        = r_h;
        n_idx      = r_idx;
        n_rstat    = r_rstat;
        n_rfound   = r_rfound;
        n_ovalid   = r_ovalid && i_stall;
        n_ostatus  = r_ostatus;
        n_ofound   = r_ofound;
        n_obucket  = r_obucket;
        o_q_pop    = 1'b0;
        head_we    = 1'b0;
        head_waddr = head_raddr;
        head_wdata = '0;
        kv_we      = 1'b0;
        kv_waddr   = new_idx;
        kv_wdata   = {r_job.key, r_job.data};
        next_we    = 1'b0;
        next_waddr = new_idx;
        next_wdata = head_rdata;
        prev_we    = 1'b0;
        prev_waddr = new_idx;
        prev_wdata = '0;
        free_we    = 1'b0;
        free_waddr = IW'(r_fc);
        free_wdata = r_idx;
        node_raddr = r_idx;

        case (r_state)
            esht_pkg::B_CLEAR: begin
                head_we    = 1'b1;
                head_waddr = r_clr;
                head_wdata = '0;
                n_clr      = r_clr + 1'b1;
                if (r_clr == IW'(ENTRIES - 1)) begin
                    n_state = esht_pkg::B_IDLE;
                end
            end
            esht_pkg::B_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop  = 1'b1;
                    n_job    = i_q_data;
                    n_rfound = '0;
                    n_state  = esht_pkg::B_RES;
                    case (i_q_data.cls)
                        esht_pkg::CLS_OFF: n_rstat = esht_pkg::ST_OFF;
                        esht_pkg::CLS_ADD: begin
                            if (r_fc == '0) begin
                                n_rstat = esht_pkg::ST_FULL;
                            end else begin
                                n_state = esht_pkg::B_ADD0;
                            end
                        end
                        esht_pkg::CLS_DEL,
                        esht_pkg::CLS_GET: n_state = esht_pkg::B_FIND0;
                        default:           n_rstat = esht_pkg::ST_MISS;
                    endcase
                end
            end
            esht_pkg::B_ADD0: begin
                n_state = esht_pkg::B_ADD1;
            end
            esht_pkg::B_ADD1: begin
                // link the popped node at the head of its chain
                kv_we      = 1'b1;
                next_we    = 1'b1;
                prev_we    = 1'b1;
                head_we    = 1'b1;
                head_wdata = LW'(new_idx) + 1'b1;
                n_fc       = pos;
                if (pos < r_virt) begin
                    n_virt = pos;
                end
                n_h     = head_rdata;
                n_idx   = new_idx;
                n_state = esht_pkg::B_ADD2;
            end
            esht_pkg::B_ADD2: begin
                if (r_h != '0) begin
                    prev_we    = 1'b1;
                    prev_waddr = IW'(r_h - 1'b1);
                    prev_wdata = LW'(r_idx) + 1'b1;
                end
                n_rstat = esht_pkg::ST_OK;
                n_state = esht_pkg::B_RES;
            end
            esht_pkg::B_FIND0: begin
                n_state = esht_pkg::B_FIND1;
            end
            esht_pkg::B_FIND1: begin
                if (head_rdata == '0) begin
                    n_rstat = esht_pkg::ST_MISS;
                    n_state = esht_pkg::B_RES;
                end else begin
                    node_raddr = IW'(head_rdata - 1'b1);
                    n_idx      = node_raddr;
                    n_state    = esht_pkg::B_WALK;
                end
            end
            esht_pkg::B_WALK: begin
                if (kv_rdata[KW-1:esht_pkg::DATA_W] == r_job.key) begin
                    n_rstat = esht_pkg::ST_OK;
                    n_state = esht_pkg::B_RES;
                    if (r_job.cls == esht_pkg::CLS_GET) begin
                        n_rfound = kv_rdata[esht_pkg::DATA_W-1:0];
                    end else begin
                        // unlink and push the node back on the pool
                        if (prev_rdata != '0) begin
                            next_we    = 1'b1;
                            next_waddr = IW'(prev_rdata - 1'b1);
                            next_wdata = next_rdata;
                        end else begin
                            head_we    = 1'b1;
                            head_wdata = next_rdata;
                        end
                        if (next_rdata != '0) begin
                            prev_we    = 1'b1;
                            prev_waddr = IW'(next_rdata - 1'b1);
                            prev_wdata = prev_rdata;
                        end
                        free_we = 1'b1;
                        n_fc    = r_fc + 1'b1;
                    end
                end else if (next_rdata == '0) begin
                    n_rstat = esht_pkg::ST_MISS;
                    n_state = esht_pkg::B_RES;
                end else begin
                    node_raddr = IW'(next_rdata - 1'b1);
                    n_idx      = node_raddr;
                end
            end
            esht_pkg::B_RES: begin
                if (!r_ovalid || !i_stall) begin
                    n_ovalid  = 1'b1;
                    n_ostatus = r_rstat;
                    n_ofound  = r_rfound;
                    n_obucket = r_job.bucket[esht_pkg::OUT_BUCKET_W-1:0];
                    n_state   = esht_pkg::B_IDLE;
                end
            end
            default: begin
                n_state = esht_pkg::B_IDLE;
            end
        endcase

        // a size write empties every bucket and refills the pool
        if (i_cfg_we) begin
            n_state = esht_pkg::B_CLEAR;
            n_clr   = '0;
            n_fc    = i_cfg_n;
            n_virt  = i_cfg_n;
        end
    end

`ifndef SYNTHESIS
    a_fc_le_n: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fc <= i_n)
        else $error("free count above table size");
    a_virt_le_fc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_virt <= r_fc)
        else $error("untouched pool region above free count");
    a_walk_cls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == esht_pkg::B_WALK) |->
        (r_job.cls == esht_pkg::CLS_DEL || r_job.cls == esht_pkg::CLS_GET))
        else $error("chain walk for a job that needs none");
    a_no_pop_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == esht_pkg::B_CLEAR) |-> !o_q_pop)
        else $error("job taken during clearing pass");
`endif

endmodule

@@ bench/endpoint_session_hash_table_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// endpoint_session_hash_table_tb: self-checking bench of the session table
// Drives add, delete, look-up and no-op transactions at several table sizes and
// compares every result against a behavioral copy of the chained table.
// ----------------------------------------------------------------------------
module endpoint_session_hash_table_tb;
    import esht_pkg::*;

    localparam int NODES      = 1024;
    localparam int IDLE_LIMIT = 20000;

    typedef struct {
        logic [1:0]  status;
        logic [31:0] payload;
        logic [9:0]  bucket;
    } t_result;

    // Behavioral session table plus the queue of results it predicts.
    class session_scoreboard;
        int unsigned    size_used;
        int unsigned    head[NODES];
        logic [47:0]    key_of[NODES];
        logic [31:0]    data_of[NODES];
        int unsigned    next_of[NODES];
        int unsigned    prev_of[NODES];
        int unsigned    free_list[NODES];
        int unsigned    free_num;
        t_result        pending[$];
        int             errors;

        function void set_size(int unsigned value);
            size_used = (value > NODES) ? NODES : value;
            foreach (head[i]) head[i] = 0;
            for (int i = 0; i < size_used; i++) free_list[i] = size_used - 1 - i;
            free_num = size_used;
        endfunction

        function int unsigned find_link(int unsigned b, logic [47:0] key);
            int unsigned link;
            int unsigned steps;
            link = head[b];
            steps = 0;
            while (link != 0 && steps < NODES) begin
                if (key_of[link-1] == key) return link;
                link = next_of[link-1];
                steps++;
            end
            return 0;
        endfunction

        function void note_request(logic [1:0] cmd, logic [31:0] addr, logic [15:0] port,
                                   logic [31:0] data);
            t_result     r;
            logic [47:0] key;
            int unsigned b, link, idx, p, nx;
            key = {addr, port};
            r.status = ST_MISS;
            r.payload = '0;
            r.bucket = '0;
            if (size_used == 0) begin
                r.status = ST_OFF;
                pending.push_back(r);
                return;
            end
            b = (int'(addr[31:16]) + int'(addr[15:0]) + int'(port)) % size_used;
            r.bucket = b[9:0];
            case (cmd)
                CMD_ADD: begin
                    if (free_num == 0) begin
                        r.status = ST_FULL;
                    end else begin
                        free_num--;
                        idx = free_list[free_num];
                        key_of[idx] = key;
                        data_of[idx] = data;
                        prev_of[idx] = 0;
                        next_of[idx] = head[b];
                        if (head[b] != 0) prev_of[head[b]-1] = idx + 1;
                        head[b] = idx + 1;
                        r.status = ST_OK;
                    end
                end
                CMD_DEL: begin
                    link = find_link(b, key);
                    if (link != 0) begin
                        idx = link - 1;
                        p = prev_of[idx];
                        nx = next_of[idx];
                        if (p != 0) next_of[p-1] = nx;
                        else head[b] = nx;
                        if (nx != 0) prev_of[nx-1] = p;
                        free_list[free_num] = idx;
                        free_num++;
                        r.status = ST_OK;
                    end
                end
                CMD_GET: begin
                    link = find_link(b, key);
                    if (link != 0) begin
                        r.payload = data_of[link-1];
                        r.status = ST_OK;
                    end
                end
                default: ;
            endcase
            pending.push_back(r);
        endfunction

        function void check_result(logic [1:0] status, logic [31:0] payload, logic [9:0] bucket);
            t_result e;
            if (pending.size() == 0) begin
                $error("result with none expected: status %0d", status);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (status !== e.status) begin
                $error("status: expected %0d, actual %0d", e.status, status);
                errors++;
            end
            if (payload !== e.payload) begin
                $error("found_payload: expected %h, actual %h", e.payload, payload);
                errors++;
            end
            if (bucket !== e.bucket) begin
                $error("bucket: expected %0d, actual %0d", e.bucket, bucket);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [10:0] table_size = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  command = '0;
    logic [31:0] address = '0;
    logic [15:0] port = '0;
    logic [31:0] payload = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  out_status;
    logic [31:0] out_payload;
    logic [9:0]  out_bucket;

    session_scoreboard sb;
    int          idle_cycles = 0;
    bit          hold_output = 1'b0;
    bit          sink_random = 1'b1;
    logic [47:0] key_pool[16];

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    endpoint_session_hash_table u_top (
        .i_clk(clk), .i_rst_n(rst_n), .i_cfg_we(cfg_we), .i_table_size(table_size),
        .i_valid(in_valid), .o_stall(in_stall), .i_command(command),
        .i_address(address), .i_port(port), .i_payload(payload),
        .o_valid(out_valid), .i_stall(out_stall), .o_status(out_status),
        .o_found_payload(out_payload), .o_bucket(out_bucket)
    );

    // Check results and watch for a hang.
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(out_status, out_payload, out_bucket);
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // Receiver: random stall per transaction, or a long hold when asked.
    initial begin
        int gap;
        forever begin
            @(negedge clk);
            if (hold_output) begin
                out_stall <= 1'b1;
            end else if (sink_random && out_valid && out_stall == 1'b0) begin
                gap = $urandom_range(0, 4);
                if (gap != 0) begin
                    out_stall <= 1'b1;
                    repeat (gap) @(negedge clk);
                    out_stall <= 1'b0;
                end
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    // Valid stays high into a back-to-back transaction; drop it on a gap.
    task automatic send_item(logic [1:0] cmd, logic [31:0] addr, logic [15:0] prt,
                             logic [31:0] data);
        int gap;
        gap = $urandom_range(0, 4);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        command <= cmd;
        address <= addr;
        port <= prt;
        payload <= data;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
        sb.note_request(cmd, addr, prt, data);
        @(negedge clk);
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    task automatic write_size(int unsigned value);
        drain();
        table_size <= value[10:0];
        cfg_we <= 1'b1;
        @(posedge clk);
        sb.set_size(value);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Well-formed traffic mostly reuses a small key pool so deletes and hits occur.
    task automatic random_items(int count);
        logic [47:0] k;
        logic [1:0]  cmd;
        int          pick;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(0, 9);
            if (pick < 8) k = key_pool[$urandom_range(0, 15)];
            else k = {$urandom(), 16'($urandom())};
            pick = $urandom_range(0, 19);
            if (pick < 8) cmd = CMD_ADD;
            else if (pick < 13) cmd = CMD_DEL;
            else if (pick < 19) cmd = CMD_GET;
            else cmd = CMD_NOP;
            send_item(cmd, k[47:16], k[15:0], $urandom());
        end
    endtask

    task automatic new_pool;
        foreach (key_pool[i]) key_pool[i] = {$urandom(), 16'($urandom())};
        key_pool[0] = '1;
        key_pool[1] = '0;
    endtask

    initial begin
        sb = new();
        sb.set_size(0);
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (1100) @(negedge clk);

        // Disabled table: every command reports the table off.
        send_item(CMD_ADD, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
        send_item(CMD_GET, '0, '0, '0);
        send_item(CMD_NOP, 32'h1234_5678, 16'h9ABC, '0);

        // Size one: pool full on the second add, then a hit, a delete and misses.
        write_size(1);
        send_item(CMD_ADD, 32'hFFFF_FFFF, 16'hFFFF, 32'hDEAD_BEEF);
        send_item(CMD_ADD, 32'h0000_0001, 16'h0002, 32'h1);
        send_item(CMD_GET, 32'hFFFF_FFFF, 16'hFFFF, '0);
        send_item(CMD_DEL, 32'hFFFF_FFFF, 16'hFFFF, '0);
        send_item(CMD_DEL, 32'hFFFF_FFFF, 16'hFFFF, '0);
        send_item(CMD_GET, 32'hFFFF_FFFF, 16'hFFFF, '0);
        send_item(CMD_NOP, 32'hFFFF_FFFF, 16'hFFFF, '1);

        // Above the node store: clamps to the full size; duplicates chain.
        write_size(2047);
        send_item(CMD_ADD, 32'hFFFF_FFFF, 16'hFFFF, 32'hA);
        send_item(CMD_ADD, 32'hFFFF_FFFF, 16'hFFFF, 32'hB);
        send_item(CMD_ADD, 32'h0000_0000, 16'h0000, 32'hC);
        send_item(CMD_GET, 32'hFFFF_FFFF, 16'hFFFF, '0);
        send_item(CMD_DEL, 32'hFFFF_FFFF, 16'hFFFF, '0);
        send_item(CMD_GET, 32'hFFFF_FFFF, 16'hFFFF, '0);
        send_item(CMD_GET, 32'h0000_0000, 16'h0000, '0);
        send_item(CMD_DEL, 32'h5555_AAAA, 16'h5A5A, '0);

        // Random phases over several sizes, extremes among them.
        foreach (key_pool[i]) key_pool[i] = '0;
        write_size(3);
        new_pool();
        random_items(300);
        write_size(1024);
        new_pool();
        random_items(350);

        // Long receiver hold while the sender keeps offering.
        fork
            begin
                hold_output = 1'b1;
                repeat (600) @(negedge clk);
                hold_output = 1'b0;
            end
            random_items(30);
        join
        drain();

        write_size(7);
        new_pool();
        random_items(350);
        write_size(1);
        new_pool();
        random_items(150);
        write_size(0);
        random_items(50);
        write_size(1000);
        new_pool();
        random_items(300);
        write_size(2);
        new_pool();
        random_items(300);

        drain();
        repeat (100) @(negedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
